@@ hw/rtl/plfp_pkg.sv @@
// Package for the playlist line field parser: parse phases, lexer flag bits,
// parser state record, result record and the state after reset.
// No dependencies.
package plfp_pkg;

  typedef enum logic [4:0] {
    PH_NAME, PH_TYPE, PH_TYPE_COMMA, PH_SONG, PH_SONG_COMMA, PH_TITLE,
    PH_TITLE_COMMA, PH_T_START, PH_T_H, PH_T_C1, PH_T_M, PH_T_C2, PH_T_S,
    PH_T_Q, PH_T_CC, PH_PLAY_COMMA, PH_LOOP_DASH, PH_LOOP_COMMA,
    PH_FADE_COMMA, PH_LOOPCOUNT, PH_VOL_COMMA, PH_VOL_DASH, PH_VOL_NUM,
    PH_QMARK, PH_PAN, PH_DONE
  } phase_t;

  localparam int FB_BODY  = 0;
  localparam int FB_TRAIL = 1;
  localparam int FB_PEND  = 2;
  localparam int FB_HEX   = 3;
  localparam int FB_RAW   = 4;
  localparam int FB_NEG   = 5;

  localparam int NUM_REC = 13;
  localparam logic [3:0] REC_LAST = 4'd12;
  localparam logic [3:0] KIND_NAME = 4'd0;
  localparam logic [3:0] KIND_TITLE = 4'd1;
  localparam logic [3:0] KIND_REC_BASE = 4'd2;
  localparam logic [8:0] EOT_CODE = 9'h100;
  localparam logic [31:0] VOL_OFF = 32'd128;
  localparam logic [31:0] PAN_DEFAULT = 32'h07ED_E79E;

  typedef struct packed {
    phase_t                     phase;
    logic [31:0]                num;
    logic [31:0]                tim;
    logic [5:0]                 flags;
    logic [3:0][7:0]            tchars;
    logic [2:0]                 item;
    logic [NUM_REC-1:0][31:0]   rec;
  } state_t;

  typedef struct packed {
    logic        vld;
    logic [3:0]  kind;
    logic [31:0] value;
  } emit_t;

  function automatic state_t reset_state();
    state_t s;
    s = '0;
    s.phase = PH_NAME;
    s.rec[2] = '1;
    s.rec[3] = '1;
    s.rec[4] = '1;
    s.rec[5] = '1;
    return s;
  endfunction

endpackage

@@ hw/rtl/plfp_if.sv @@
// Valid/ready channel interfaces for the playlist line field parser.
// Depends on nothing.
interface plfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;
  modport source (output valid, char_byte, end_of_text, input ready);
  modport sink (input valid, char_byte, end_of_text, output ready);
endinterface

interface plfp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         field_kind;
  logic signed [31:0] field_value;
  logic               last_of_record;
  modport source (output valid, field_kind, field_value, last_of_record, input ready);
  modport sink (input valid, field_kind, field_value, last_of_record, output ready);
endinterface

@@ hw/rtl/plfp_feed.sv @@
// One lexer step: applies one byte (or the end code) to the parser state.
// Depends on plfp_pkg.
module plfp_feed (
  input  plfp_pkg::state_t st,
  input  logic [8:0]       c,
  output plfp_pkg::state_t nx,
  output logic             consumed,
  output plfp_pkg::emit_t  em
);

  logic        sp;
  logic        eot;
  logic        title;
  logic        out_char;
  logic        lead;
  logic        dvld;
  logic [3:0]  dig;
  logic [31:0] v;

  function automatic logic is_ch(logic [8:0] x, logic [7:0] ch);
    return !x[8] && (x[7:0] == ch);
  endfunction

  function automatic plfp_pkg::state_t time_done(plfp_pkg::state_t s, logic [31:0] tv);
    case (s.item)
      3'd0: begin
        s.rec[2] = tv;
        s.phase = (tv == '1 && s.rec[0] == 32'd1) ? plfp_pkg::PH_DONE
                                                   : plfp_pkg::PH_PLAY_COMMA;
      end
      3'd1: begin
        s.rec[3] = tv;
        s.phase = plfp_pkg::PH_LOOP_DASH;
      end
      default: begin
        s.rec[4] = tv;
        s.phase = plfp_pkg::PH_FADE_COMMA;
      end
    endcase
    return s;
  endfunction

  function automatic logic [31:0] number_default(plfp_pkg::phase_t p);
    case (p)
      plfp_pkg::PH_LOOPCOUNT: return '1;
      plfp_pkg::PH_VOL_NUM:   return plfp_pkg::VOL_OFF;
      plfp_pkg::PH_PAN:       return plfp_pkg::PAN_DEFAULT;
      default:                return '0;
    endcase
  endfunction

  function automatic plfp_pkg::state_t number_done(plfp_pkg::state_t s, logic [31:0] nv);
    logic [31:0] m;
    logic [31:0] vol;
    logic [3:0]  idx;
    logic [1:0]  i;
    m = '0;
    vol = '0;
    i = s.item[1:0];
    idx = 4'd6 + {2'b00, i};
    case (s.phase)
      plfp_pkg::PH_SONG: begin
        s.rec[1] = nv;
        s.phase = plfp_pkg::PH_SONG_COMMA;
      end
      plfp_pkg::PH_T_H: begin
        s.tim = nv;
        s.phase = plfp_pkg::PH_T_C1;
      end
      plfp_pkg::PH_T_M: begin
        s.tim = s.tim * 32'd60 + nv;
        s.phase = plfp_pkg::PH_T_C2;
      end
      plfp_pkg::PH_T_S: begin
        s.tim = (s.tim * 32'd60 + nv) * 32'd1000;
        s.phase = plfp_pkg::PH_T_Q;
      end
      plfp_pkg::PH_T_CC: begin
        s.tim = s.tim + nv * 32'd10;
        s = time_done(s, s.tim);
      end
      plfp_pkg::PH_LOOPCOUNT: begin
        s.rec[5] = nv;
        s.item = '0;
        s.phase = plfp_pkg::PH_VOL_COMMA;
      end
      plfp_pkg::PH_VOL_NUM: begin
        m = ($signed(nv) < $signed(plfp_pkg::VOL_OFF)) ? nv : plfp_pkg::VOL_OFF;
        vol = s.flags[plfp_pkg::FB_NEG] ? (32'd0 - m) : m;
        if (vol != plfp_pkg::VOL_OFF) begin
          s.rec[idx] = vol;
          s.rec[10][i] = 1'b1;
        end else begin
          s.rec[idx] = '0;
          s.rec[10][i] = 1'b0;
        end
        s.flags[plfp_pkg::FB_NEG] = 1'b0;
        s.item = 3'(s.item + 3'd1);
        s.phase = (s.item >= 3'd4) ? plfp_pkg::PH_QMARK : plfp_pkg::PH_VOL_COMMA;
      end
      default: begin
        s.rec[12] = nv;
        s.phase = plfp_pkg::PH_DONE;
      end
    endcase
    return s;
  endfunction

  function automatic plfp_pkg::state_t type_store(plfp_pkg::state_t s, logic [8:0] x);
    if (s.num < 32'd4) begin
      s.tchars[s.num[1:0]] = x[7:0];
      s.num = s.num + 32'd1;
    end
    return s;
  endfunction

  function automatic logic [31:0] type_code(plfp_pkg::state_t s);
    logic [23:0] t;
    t = {s.tchars[0], s.tchars[1], s.tchars[2]};
    if (s.num != 32'd3) return '0;
    if (t == "KSS" || t == "kss") return 32'd1;
    if (t == "MSX" || t == "msx") return 32'd2;
    if (t == "NSF" || t == "nsf") return 32'd3;
    return '0;
  endfunction

  function automatic logic check_stop(logic [8:0] x, logic [7:0] want);
    return is_ch(x, want);
  endfunction

  always_comb begin
    nx = st;
    consumed = 1'b0;
    em = '0;
    out_char = 1'b0;
    v = '0;
    eot = c[8];
    sp = is_ch(c, " ") || is_ch(c, 8'h09);
    title = (st.phase == plfp_pkg::PH_TITLE);
    lead = !c[8] && ((c[7:0] >= 8'h81 && c[7:0] <= 8'h9F) ||
                     (c[7:0] >= 8'hE0 && c[7:0] <= 8'hFC));
    dig = 4'd0;
    dvld = 1'b0;
    if (!c[8] && c[7:0] >= "0" && c[7:0] <= "9") begin
      dig = 4'(c[7:0] - 8'h30);
      dvld = 1'b1;
    end else if (st.flags[plfp_pkg::FB_HEX] && !c[8] && c[7:0] >= "a" && c[7:0] <= "f") begin
      dig = 4'(c[7:0] - 8'h57);
      dvld = 1'b1;
    end else if (st.flags[plfp_pkg::FB_HEX] && !c[8] && c[7:0] >= "A" && c[7:0] <= "F") begin
      dig = 4'(c[7:0] - 8'h37);
      dvld = 1'b1;
    end

    unique case (st.phase)
      plfp_pkg::PH_NAME, plfp_pkg::PH_TITLE: begin
        if (!st.flags[plfp_pkg::FB_BODY] && sp) begin
          consumed = 1'b1;
        end else begin
          nx.flags[plfp_pkg::FB_BODY] = 1'b1;
          if (st.flags[plfp_pkg::FB_TRAIL]) begin
            nx.flags[plfp_pkg::FB_TRAIL] = 1'b0;
            if (!eot) begin
              em = '{vld: 1'b1, kind: title ? plfp_pkg::KIND_TITLE : plfp_pkg::KIND_NAME,
                     value: {24'd0, c[7:0]}};
              consumed = 1'b1;
            end
          end else if (!title) begin
            if (st.flags[plfp_pkg::FB_PEND]) begin
              nx.flags[plfp_pkg::FB_PEND] = 1'b0;
              if (is_ch(c, ":")) begin
                nx.flags = '0;
                nx.phase = plfp_pkg::PH_TYPE;
                consumed = 1'b1;
              end else begin
                em = '{vld: 1'b1, kind: plfp_pkg::KIND_NAME, value: 32'h3A};
              end
            end else if (eot) begin
              nx.flags = '0;
              nx.phase = plfp_pkg::PH_DONE;
            end else if (is_ch(c, ":")) begin
              nx.flags[plfp_pkg::FB_PEND] = 1'b1;
              consumed = 1'b1;
            end else begin
              out_char = 1'b1;
            end
          end else begin
            if (st.flags[plfp_pkg::FB_PEND]) begin
              nx.flags[plfp_pkg::FB_PEND] = 1'b0;
              out_char = !eot;
            end else if (is_ch(c, ",") || eot) begin
              nx.flags = '0;
              nx.phase = plfp_pkg::PH_TITLE_COMMA;
            end else if (is_ch(c, "\\")) begin
              nx.flags[plfp_pkg::FB_PEND] = 1'b1;
              consumed = 1'b1;
            end else begin
              out_char = 1'b1;
            end
          end
          if (out_char) begin
            em = '{vld: 1'b1, kind: title ? plfp_pkg::KIND_TITLE : plfp_pkg::KIND_NAME,
                   value: {24'd0, c[7:0]}};
            if (lead) nx.flags[plfp_pkg::FB_TRAIL] = 1'b1;
            consumed = 1'b1;
          end
        end
      end
      plfp_pkg::PH_TYPE: begin
        if (!st.flags[plfp_pkg::FB_BODY] && sp) begin
          consumed = 1'b1;
        end else begin
          if (!st.flags[plfp_pkg::FB_BODY]) begin
            nx.flags[plfp_pkg::FB_BODY] = 1'b1;
            nx.num = '0;
          end
          if (st.flags[plfp_pkg::FB_TRAIL]) begin
            nx.flags[plfp_pkg::FB_TRAIL] = 1'b0;
            if (!eot) begin
              nx = type_store(nx, c);
              consumed = 1'b1;
            end
          end else if (is_ch(c, ",") || eot || sp) begin
            nx.rec[0] = type_code(nx);
            nx.num = '0;
            nx.flags = '0;
            nx.phase = plfp_pkg::PH_TYPE_COMMA;
          end else begin
            nx = type_store(nx, c);
            if (lead) nx.flags[plfp_pkg::FB_TRAIL] = 1'b1;
            consumed = 1'b1;
          end
        end
      end
      plfp_pkg::PH_SONG, plfp_pkg::PH_T_H, plfp_pkg::PH_T_M, plfp_pkg::PH_T_S,
      plfp_pkg::PH_T_CC, plfp_pkg::PH_LOOPCOUNT, plfp_pkg::PH_VOL_NUM,
      plfp_pkg::PH_PAN: begin
        if (!st.flags[plfp_pkg::FB_BODY]) begin
          if (sp) begin
            consumed = 1'b1;
          end else if (eot) begin
            nx = number_done(nx, '0);
          end else begin
            nx.flags[plfp_pkg::FB_HEX] = 1'b0;
            nx.flags[plfp_pkg::FB_RAW] = 1'b0;
            nx.flags[plfp_pkg::FB_BODY] = 1'b1;
            nx.num = '0;
            if (is_ch(c, "$")) begin
              nx.flags[plfp_pkg::FB_HEX] = 1'b1;
              consumed = 1'b1;
            end
          end
        end else if (dvld) begin
          nx.num = st.flags[plfp_pkg::FB_HEX] ? ({st.num[27:0], 4'd0} + {28'd0, dig})
                                              : (st.num * 32'd10 + {28'd0, dig});
          nx.flags[plfp_pkg::FB_RAW] = 1'b1;
          consumed = 1'b1;
        end else begin
          v = st.flags[plfp_pkg::FB_RAW] ? st.num : number_default(st.phase);
          nx.flags[plfp_pkg::FB_BODY] = 1'b0;
          nx.flags[plfp_pkg::FB_HEX] = 1'b0;
          nx.flags[plfp_pkg::FB_RAW] = 1'b0;
          nx = number_done(nx, v);
        end
      end
      plfp_pkg::PH_DONE: consumed = 1'b1;
      default: begin
        if (sp) begin
          consumed = 1'b1;
        end else begin
          case (st.phase)
            plfp_pkg::PH_TYPE_COMMA: begin
              consumed = check_stop(c, ",");
              nx.phase = !consumed ? plfp_pkg::PH_DONE :
                         (st.rec[0] == 32'd0) ? plfp_pkg::PH_DONE : plfp_pkg::PH_SONG;
            end
            plfp_pkg::PH_SONG_COMMA: begin
              consumed = check_stop(c, ",");
              if (consumed && st.rec[0] == 32'd3) nx.rec[1] = st.rec[1] - 32'd1;
              nx.phase = consumed ? plfp_pkg::PH_TITLE : plfp_pkg::PH_DONE;
            end
            plfp_pkg::PH_TITLE_COMMA, plfp_pkg::PH_PLAY_COMMA,
            plfp_pkg::PH_LOOP_COMMA: begin
              nx.item = (st.phase == plfp_pkg::PH_TITLE_COMMA) ? 3'd0 :
                        (st.phase == plfp_pkg::PH_PLAY_COMMA) ? 3'd1 : 3'd2;
              consumed = check_stop(c, ",");
              nx.phase = consumed ? plfp_pkg::PH_T_START : plfp_pkg::PH_DONE;
            end
            plfp_pkg::PH_FADE_COMMA: begin
              consumed = check_stop(c, ",");
              nx.phase = consumed ? plfp_pkg::PH_LOOPCOUNT : plfp_pkg::PH_DONE;
            end
            plfp_pkg::PH_VOL_COMMA: begin
              consumed = check_stop(c, ",");
              nx.phase = consumed ? plfp_pkg::PH_VOL_DASH : plfp_pkg::PH_DONE;
            end
            plfp_pkg::PH_T_START: begin
              if (!c[8] && c[7:0] >= "0" && c[7:0] <= "9") begin
                nx.tim = '0;
                nx.phase = plfp_pkg::PH_T_H;
              end else begin
                nx = time_done(nx, '1);
              end
            end
            plfp_pkg::PH_T_C1, plfp_pkg::PH_T_C2: begin
              if (is_ch(c, ":")) begin
                nx.phase = (st.phase == plfp_pkg::PH_T_C1) ? plfp_pkg::PH_T_M
                                                             : plfp_pkg::PH_T_S;
                consumed = 1'b1;
              end else begin
                nx.tim = st.tim * 32'd1000;
                nx.phase = plfp_pkg::PH_T_Q;
              end
            end
            plfp_pkg::PH_T_Q: begin
              if (is_ch(c, "'")) begin
                nx.phase = plfp_pkg::PH_T_CC;
                consumed = 1'b1;
              end else begin
                nx = time_done(nx, st.tim);
              end
            end
            plfp_pkg::PH_LOOP_DASH: begin
              nx.phase = plfp_pkg::PH_LOOP_COMMA;
              if (is_ch(c, "-")) begin
                nx.rec[3] = st.rec[2] - st.rec[3];
                consumed = 1'b1;
              end
            end
            plfp_pkg::PH_VOL_DASH: begin
              nx.phase = plfp_pkg::PH_VOL_NUM;
              nx.flags[plfp_pkg::FB_NEG] = is_ch(c, "-");
              consumed = is_ch(c, "-");
            end
            plfp_pkg::PH_QMARK: begin
              consumed = check_stop(c, "?");
              if (consumed) nx.rec[11] = 32'd1;
              nx.phase = consumed ? plfp_pkg::PH_PAN : plfp_pkg::PH_DONE;
            end
            default: begin
              nx.phase = plfp_pkg::PH_DONE;
              consumed = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

endmodule

@@ hw/rtl/playlist_line_field_parser_core.sv @@
// Top level of the playlist line field parser: byte holding register, lexer
// step, record sequencer and output register.
// Depends on plfp_pkg, plfp_if.sv and plfp_feed.
//
// A playlist line enters one byte per transaction, closed by a transaction
// with end_of_text set. Name and title bytes leave as they are recognized;
// the end marker produces a 13-transaction record (type through pan), the
// last one flagged by last_of_record, after which the parser is back in its
// reset state. The byte register feeds one lexer step per cycle while the
// output register is free: a byte inside a field takes one step, a byte
// that closes a field one step per phase it passes through, and the end
// marker its closing steps plus one step per record transaction. The output
// register lets the holding register take a new byte while a result waits.
module playlist_line_field_parser_core (
  input logic clk,
  input logic rst_n,
  plfp_in_if.sink    in_ch,
  plfp_out_if.source out_ch
);

  plfp_pkg::state_t st_r, st_nxt, fd_nx;
  plfp_pkg::emit_t  fd_em;
  logic             fd_consumed;

  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] hold_char_r;
  logic       hold_eot_r;
  logic [3:0] cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_kind_r;
  logic signed [31:0] out_value_r;
  logic               out_last_r;

  logic        out_free, active, rec_mode, release_hold, in_fire;
  logic        ld;
  logic [3:0]  ld_kind;
  logic [31:0] ld_value;
  logic        ld_last;
  logic [8:0]  c;

  assign c = hold_eot_r ? plfp_pkg::EOT_CODE : {1'b0, hold_char_r};

  plfp_feed u_feed (
    .st       (st_r),
    .c        (c),
    .nx       (fd_nx),
    .consumed (fd_consumed),
    .em       (fd_em)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign active   = hold_valid_r && out_free;
  assign rec_mode = hold_eot_r && (st_r.phase == plfp_pkg::PH_DONE);
  assign in_ch.ready = !hold_valid_r || release_hold;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    release_hold = 1'b0;
    ld = 1'b0;
    ld_kind = fd_em.kind;
    ld_value = fd_em.value;
    ld_last = 1'b0;
    if (active) begin
      if (rec_mode) begin
        ld = 1'b1;
        ld_kind = plfp_pkg::KIND_REC_BASE + cnt_r;
        ld_value = st_r.rec[cnt_r];
        ld_last = (cnt_r == plfp_pkg::REC_LAST);
        if (ld_last) begin
          st_nxt = plfp_pkg::reset_state();
          cnt_nxt = '0;
          release_hold = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end else begin
        st_nxt = fd_nx;
        ld = fd_em.vld;
        release_hold = !hold_eot_r && fd_consumed;
      end
    end
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (release_hold) hold_valid_nxt = 1'b0;
    if (in_fire) hold_valid_nxt = 1'b1;
    out_valid_nxt = out_free ? ld : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= plfp_pkg::reset_state();
      hold_valid_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      hold_valid_r <= hold_valid_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_char_r <= in_ch.char_byte;
      hold_eot_r <= in_ch.end_of_text;
    end
    if (out_free && ld) begin
      out_kind_r <= ld_kind;
      out_value_r <= ld_value;
      out_last_r <= ld_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.field_kind = out_kind_r;
  assign out_ch.field_value = out_value_r;
  assign out_ch.last_of_record = out_last_r;

endmodule

@@ sim/tb_top.sv @@
// Testbench for playlist_line_field_parser_core: playlist lines go in byte by byte,
// and a built-in line parser predicts every name, title and record transaction.
// Depends on plfp_pkg, plfp_if.sv and the core RTL.
module tb_top;

  localparam int LIMIT = 400000;
  localparam logic [31:0] TYPE_NONE = 32'd0;
  localparam logic [31:0] TYPE_KSS = 32'd1;
  localparam logic [31:0] TYPE_MSX = 32'd2;
  localparam logic [31:0] TYPE_NSF = 32'd3;
  localparam int MAX_PER_ITEM = 14;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        last;
  } field_res_t;

  logic clk;
  logic rst_n;
  plfp_in_if in_bus();
  plfp_out_if out_bus();

  playlist_line_field_parser_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus)
  );

  field_res_t pending_fields[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  byte unsigned line_q[$];

  plfp_pkg::phase_t ph;
  logic [31:0] acc_num, acc_time, itm;
  logic [5:0] lx;
  logic [7:0] tch[4];
  logic [31:0] rec[13];
  int n_emit;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void parser_reset();
    ph = plfp_pkg::PH_NAME;
    acc_num = 0;
    acc_time = 0;
    lx = 0;
    itm = 0;
    for (int i = 0; i < 4; i++) tch[i] = 0;
    for (int i = 0; i < 13; i++) rec[i] = (i >= 2 && i < 6) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function automatic void put(logic [3:0] k, logic [31:0] v, logic l);
    field_res_t r;
    if (n_emit < MAX_PER_ITEM) begin
      r.kind = k;
      r.value = v;
      r.last = l;
      pending_fields.push_back(r);
      n_emit++;
    end
  endfunction

  function automatic bit is_lead(int c);
    return (c >= 'h81 && c <= 'h9F) || (c >= 'hE0 && c <= 'hFC);
  endfunction

  function automatic bit is_dec(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void type_store(int c);
    if (acc_num < 4) begin
      tch[acc_num[1:0]] = c[7:0];
      acc_num++;
    end
  endfunction

  function automatic logic [31:0] type_code();
    logic [23:0] t;
    if (acc_num != 3) return TYPE_NONE;
    t = {tch[0], tch[1], tch[2]};
    if (t == "KSS" || t == "kss") return TYPE_KSS;
    if (t == "MSX" || t == "msx") return TYPE_MSX;
    if (t == "NSF" || t == "nsf") return TYPE_NSF;
    return TYPE_NONE;
  endfunction

  function automatic void time_done(logic [31:0] v);
    logic [31:0] i;
    i = (itm > 2) ? 32'd2 : itm;
    rec[2 + i] = v;
    if (i == 0) ph = (v == 32'hFFFF_FFFF && rec[0] == TYPE_KSS) ? plfp_pkg::PH_DONE
                                                                : plfp_pkg::PH_PLAY_COMMA;
    else if (i == 1) ph = plfp_pkg::PH_LOOP_DASH;
    else ph = plfp_pkg::PH_FADE_COMMA;
  endfunction

  function automatic logic [31:0] number_default();
    case (ph)
      plfp_pkg::PH_LOOPCOUNT: return 32'hFFFF_FFFF;
      plfp_pkg::PH_VOL_NUM: return plfp_pkg::VOL_OFF;
      plfp_pkg::PH_PAN: return plfp_pkg::PAN_DEFAULT;
      default: return 32'd0;
    endcase
  endfunction

  function automatic void number_done(logic [31:0] v);
    logic [31:0] m, vol;
    int i;
    case (ph)
      plfp_pkg::PH_SONG: begin
        rec[1] = v;
        ph = plfp_pkg::PH_SONG_COMMA;
      end
      plfp_pkg::PH_T_H: begin
        acc_time = v;
        ph = plfp_pkg::PH_T_C1;
      end
      plfp_pkg::PH_T_M: begin
        acc_time = acc_time * 60 + v;
        ph = plfp_pkg::PH_T_C2;
      end
      plfp_pkg::PH_T_S: begin
        acc_time = (acc_time * 60 + v) * 1000;
        ph = plfp_pkg::PH_T_Q;
      end
      plfp_pkg::PH_T_CC: begin
        acc_time = acc_time + v * 10;
        time_done(acc_time);
      end
      plfp_pkg::PH_LOOPCOUNT: begin
        rec[5] = v;
        itm = 0;
        ph = plfp_pkg::PH_VOL_COMMA;
      end
      plfp_pkg::PH_VOL_NUM: begin
        m = ($signed(v) < $signed(plfp_pkg::VOL_OFF)) ? v : plfp_pkg::VOL_OFF;
        vol = lx[plfp_pkg::FB_NEG] ? -m : m;
        i = itm[1:0];
        if (vol != plfp_pkg::VOL_OFF) begin
          rec[6 + i] = vol;
          rec[10][i] = 1'b1;
        end else begin
          rec[6 + i] = 0;
          rec[10][i] = 1'b0;
        end
        lx[plfp_pkg::FB_NEG] = 1'b0;
        itm++;
        ph = (itm >= 4) ? plfp_pkg::PH_QMARK : plfp_pkg::PH_VOL_COMMA;
      end
      default: begin
        rec[12] = v;
        ph = plfp_pkg::PH_DONE;
      end
    endcase
  endfunction

  function automatic bit number_byte(int c, bit sp);
    int d;
    logic [31:0] v;
    d = -1;
    if (!lx[plfp_pkg::FB_BODY]) begin
      if (sp) return 1;
      if (c == plfp_pkg::EOT_CODE) begin
        number_done(0);
        return 0;
      end
      lx[plfp_pkg::FB_HEX] = 0;
      lx[plfp_pkg::FB_RAW] = 0;
      lx[plfp_pkg::FB_BODY] = 1;
      acc_num = 0;
      if (c == "$") begin
        lx[plfp_pkg::FB_HEX] = 1;
        return 1;
      end
      return 0;
    end
    if (is_dec(c)) d = c - "0";
    else if (lx[plfp_pkg::FB_HEX] && c >= "a" && c <= "f") d = c - "a" + 10;
    else if (lx[plfp_pkg::FB_HEX] && c >= "A" && c <= "F") d = c - "A" + 10;
    if (d >= 0) begin
      acc_num = lx[plfp_pkg::FB_HEX] ? (acc_num << 4) + d : acc_num * 10 + d;
      lx[plfp_pkg::FB_RAW] = 1;
      return 1;
    end
    v = lx[plfp_pkg::FB_RAW] ? acc_num : number_default();
    lx[plfp_pkg::FB_BODY] = 0;
    lx[plfp_pkg::FB_HEX] = 0;
    lx[plfp_pkg::FB_RAW] = 0;
    number_done(v);
    return 0;
  endfunction

  function automatic bit text_byte(int c, bit sp, logic [3:0] kind);
    if (!lx[plfp_pkg::FB_BODY]) begin
      if (sp) return 1;
      lx[plfp_pkg::FB_BODY] = 1;
    end
    if (lx[plfp_pkg::FB_TRAIL]) begin
      lx[plfp_pkg::FB_TRAIL] = 0;
      if (c == plfp_pkg::EOT_CODE) return 0;
      put(kind, c, 0);
      return 1;
    end
    if (kind == plfp_pkg::KIND_NAME) begin
      if (lx[plfp_pkg::FB_PEND]) begin
        lx[plfp_pkg::FB_PEND] = 0;
        if (c == ":") begin
          lx = 0;
          ph = plfp_pkg::PH_TYPE;
          return 1;
        end
        put(plfp_pkg::KIND_NAME, ":", 0);
        return 0;
      end
      if (c == plfp_pkg::EOT_CODE) begin
        lx = 0;
        ph = plfp_pkg::PH_DONE;
        return 0;
      end
      if (c == ":") begin
        lx[plfp_pkg::FB_PEND] = 1;
        return 1;
      end
    end else begin
      if (lx[plfp_pkg::FB_PEND]) begin
        lx[plfp_pkg::FB_PEND] = 0;
        if (c == plfp_pkg::EOT_CODE) return 0;
      end else begin
        if (c == "," || c == plfp_pkg::EOT_CODE) begin
          lx = 0;
          ph = plfp_pkg::PH_TITLE_COMMA;
          return 0;
        end
        if (c == "\\") begin
          lx[plfp_pkg::FB_PEND] = 1;
          return 1;
        end
      end
    end
    put(kind, c, 0);
    if (is_lead(c)) lx[plfp_pkg::FB_TRAIL] = 1;
    return 1;
  endfunction

  function automatic bit type_byte(int c, bit sp);
    if (!lx[plfp_pkg::FB_BODY]) begin
      if (sp) return 1;
      lx[plfp_pkg::FB_BODY] = 1;
      acc_num = 0;
    end
    if (lx[plfp_pkg::FB_TRAIL]) begin
      lx[plfp_pkg::FB_TRAIL] = 0;
      if (c == plfp_pkg::EOT_CODE) return 0;
      type_store(c);
      return 1;
    end
    if (c == "," || c == plfp_pkg::EOT_CODE || sp) begin
      rec[0] = type_code();
      acc_num = 0;
      lx = 0;
      ph = plfp_pkg::PH_TYPE_COMMA;
      return 0;
    end
    type_store(c);
    if (is_lead(c)) lx[plfp_pkg::FB_TRAIL] = 1;
    return 1;
  endfunction

  function automatic bit check_or_stop(int c, int want, plfp_pkg::phase_t nxt);
    if (c == want) begin
      ph = nxt;
      return 1;
    end
    ph = plfp_pkg::PH_DONE;
    return 0;
  endfunction

  function automatic bit lexer_step(int c);
    bit sp;
    sp = (c == " " || c == "\t");
    case (ph)
      plfp_pkg::PH_NAME: return text_byte(c, sp, plfp_pkg::KIND_NAME);
      plfp_pkg::PH_TITLE: return text_byte(c, sp, plfp_pkg::KIND_TITLE);
      plfp_pkg::PH_TYPE: return type_byte(c, sp);
      plfp_pkg::PH_SONG, plfp_pkg::PH_T_H, plfp_pkg::PH_T_M, plfp_pkg::PH_T_S,
      plfp_pkg::PH_T_CC, plfp_pkg::PH_LOOPCOUNT, plfp_pkg::PH_VOL_NUM, plfp_pkg::PH_PAN:
        return number_byte(c, sp);
      plfp_pkg::PH_DONE: return 1;
      default: ;
    endcase
    if (sp) return 1;
    case (ph)
      plfp_pkg::PH_TYPE_COMMA:
        return check_or_stop(c, ",", rec[0] == TYPE_NONE ? plfp_pkg::PH_DONE
                                                          : plfp_pkg::PH_SONG);
      plfp_pkg::PH_SONG_COMMA: begin
        if (c == "," && rec[0] == TYPE_NSF) rec[1] = rec[1] - 1;
        return check_or_stop(c, ",", plfp_pkg::PH_TITLE);
      end
      plfp_pkg::PH_TITLE_COMMA: begin
        itm = 0;
        return check_or_stop(c, ",", plfp_pkg::PH_T_START);
      end
      plfp_pkg::PH_PLAY_COMMA: begin
        itm = 1;
        return check_or_stop(c, ",", plfp_pkg::PH_T_START);
      end
      plfp_pkg::PH_LOOP_COMMA: begin
        itm = 2;
        return check_or_stop(c, ",", plfp_pkg::PH_T_START);
      end
      plfp_pkg::PH_FADE_COMMA: return check_or_stop(c, ",", plfp_pkg::PH_LOOPCOUNT);
      plfp_pkg::PH_VOL_COMMA: return check_or_stop(c, ",", plfp_pkg::PH_VOL_DASH);
      plfp_pkg::PH_T_START: begin
        if (is_dec(c)) begin
          acc_time = 0;
          ph = plfp_pkg::PH_T_H;
        end else time_done(32'hFFFF_FFFF);
        return 0;
      end
      plfp_pkg::PH_T_C1, plfp_pkg::PH_T_C2: begin
        if (c == ":") begin
          ph = (ph == plfp_pkg::PH_T_C1) ? plfp_pkg::PH_T_M : plfp_pkg::PH_T_S;
          return 1;
        end
        acc_time = acc_time * 1000;
        ph = plfp_pkg::PH_T_Q;
        return 0;
      end
      plfp_pkg::PH_T_Q: begin
        if (c == "'") begin
          ph = plfp_pkg::PH_T_CC;
          return 1;
        end
        time_done(acc_time);
        return 0;
      end
      plfp_pkg::PH_LOOP_DASH: begin
        ph = plfp_pkg::PH_LOOP_COMMA;
        if (c == "-") begin
          rec[3] = rec[2] - rec[3];
          return 1;
        end
        return 0;
      end
      plfp_pkg::PH_VOL_DASH: begin
        ph = plfp_pkg::PH_VOL_NUM;
        if (c == "-") begin
          lx[plfp_pkg::FB_NEG] = 1;
          return 1;
        end
        lx[plfp_pkg::FB_NEG] = 0;
        return 0;
      end
      plfp_pkg::PH_QMARK: begin
        if (c == "?") rec[11] = 1;
        return check_or_stop(c, "?", plfp_pkg::PH_PAN);
      end
      default: begin
        ph = plfp_pkg::PH_DONE;
        return 1;
      end
    endcase
  endfunction

  function automatic void predict_fields(logic [7:0] b, logic eot);
    n_emit = 0;
    if (eot) begin
      for (int g = 0; g < 64 && ph != plfp_pkg::PH_DONE; g++)
        void'(lexer_step(int'(plfp_pkg::EOT_CODE)));
      for (int i = 0; i < plfp_pkg::NUM_REC; i++)
        put(4'(plfp_pkg::KIND_REC_BASE + i), rec[i], i == int'(plfp_pkg::REC_LAST));
      parser_reset();
    end else begin
      for (int g = 0; g < 64; g++)
        if (lexer_step(int'(b))) break;
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eot);
    int gaps;
    gaps = 0;
    if (!quiet)
      while ($urandom_range(99) < 23) gaps++;
    if (gaps > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.char_byte <= b;
    in_bus.end_of_text <= eot;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_fields(b, eot);
  endtask

  task automatic send_bytes();
    foreach (line_q[i]) send_item(line_q[i], 1'b0);
    line_q.delete();
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_bytes();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_number();
    int sel;
    sel = $urandom_range(9);
    if ($urandom_range(3) == 0) add_text($urandom_range(1) ? " " : "\t");
    if (sel == 0) return;
    if (sel < 3) add_text($sformatf("$%0h", $urandom()));
    else if (sel < 4) add_text($sformatf("%0d", $urandom()));
    else add_text($sformatf("%0d", $urandom_range(200)));
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    field_res_t e;
    out_bus.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_fields.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction kind=%0d value=%0h", $time,
                 out_bus.field_kind, out_bus.field_value);
      end else begin
        e = pending_fields.pop_front();
        if (out_bus.field_kind !== e.kind || out_bus.field_value !== e.value ||
            out_bus.last_of_record !== e.last) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d value=%0h last=%0b %s=%0d value=%0h last=%0b",
                   $time, e.kind, e.value, e.last, "actual kind", out_bus.field_kind,
                   out_bus.field_value, out_bus.last_of_record);
        end
      end
    end
  end

  task automatic test_full_lines();
    send_line("song one::NSF,3,Tit\\,le,1:02:03'45,10-,5,2,$ff,-7,128,200,?$1A");
    send_line("  a:b ::  kss , $1f ,  t ,1'5,0:0:2,3,-1,-200,$80,0,-128,?");
    send_line("x::MSX,99999999999,t,9999:9999:9999,$FFFFFFFFF,,,4,5,6,7,8,x");
  endtask

  task automatic test_early_end();
    send_line(" name only");
    send_line(":");
    send_line("x::KSS,1,t,,5");
    send_line("x::msx,");
    send_line("x::nsf,$");
    send_line("x::nsf,0,t,1:");
    send_line("x::abc,1,t");
    send_line("x::msx,1,t\\");
  endtask

  task automatic test_sjis_and_zero();
    line_q = '{8'h81, 8'h3A, 8'h00, 8'hFC, 8'h2C, 8'h3A, 8'h3A, 8'h9F};
    add_text("SS,2,");
    line_q.push_back(8'hE0);
    line_q.push_back(8'h2C);
    add_text(",5,");
    send_bytes();
    send_item(8'h00, 1'b1);
    add_text("ab");
    line_q.push_back(8'h9F);
    send_bytes();
    send_item(8'hFF, 1'b1);
    add_text("z::KSS,1,t,,junk");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    send_bytes();
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_lines();
    string types[8];
    int sent;
    types = '{"KSS", "kss", "MSX", "msx", "NSF", "nsf", "ab", " nsf "};
    sent = 0;
    while (sent < 80) begin
      if (sent > 20 && sent < 60) quiet = 1;
      else quiet = 0;
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(0, 4))
          line_q.push_back(8'($urandom_range(255) & 8'h7F | 8'h40));
        add_text("::");
        add_text(types[$urandom_range(7)]);
        add_text(",");
        add_number();
        add_text(",");
        repeat ($urandom_range(0, 3))
          line_q.push_back($urandom_range(1) ? 8'($urandom_range(255)) : 8'h5C);
        add_text(",");
        for (int t = 0; t < 3; t++) begin
          if ($urandom_range(3) != 0) add_text($sformatf("%0d", $urandom_range(99)));
          if ($urandom_range(1)) add_text($sformatf(":%0d", $urandom_range(59)));
          if ($urandom_range(1)) add_text($sformatf(":%0d", $urandom_range(59)));
          if ($urandom_range(1)) add_text($sformatf("'%0d", $urandom_range(99)));
          if (t == 1 && $urandom_range(1)) add_text("-");
          add_text(",");
        end
        add_number();
        for (int v = 0; v < 4; v++) begin
          add_text($urandom_range(2) == 0 ? ",-" : ",");
          add_number();
        end
        if ($urandom_range(1)) begin
          add_text(",?");
          add_number();
        end
        if ($urandom_range(5) == 0) repeat ($urandom_range(1, 4)) void'(line_q.pop_back());
      end
      sent += line_q.size() + 1;
      send_bytes();
      send_item(8'($urandom_range(255)), 1'b1);
    end
    quiet = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.char_byte <= 8'h00;
    in_bus.end_of_text <= 1'b0;
    parser_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_full_lines();
    test_early_end();
    wait_drained();
    test_sjis_and_zero();
    test_random_lines();
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_fields.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
